// ===== rtl/tcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpr_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console page renderer.
// ----------------------------------------------------------------------------
package tcpr_pkg;

  localparam int COLUMNS       = 128;
  localparam int LINES         = 8;
  localparam int GLYPH_COLUMNS = 5;
  localparam int FIRST_CODE    = 32;
  localparam int LAST_CODE     = 126;

  localparam int CELL_WIDTH    = GLYPH_COLUMNS + 1;
  localparam int FRAME_SIZE    = COLUMNS * LINES;
  localparam int GLYPH_COUNT   = LAST_CODE - FIRST_CODE + 1;
  localparam int GLYPH_SIZE    = GLYPH_COUNT * GLYPH_COLUMNS;
  localparam int TAB_CELLS     = 4;
  localparam int FALLBACK_CODE = 63;
  localparam int SPACE_CODE    = 32;

  localparam int FB_AW  = $clog2(FRAME_SIZE);
  localparam int GL_AW  = $clog2(GLYPH_SIZE);
  localparam int COL_W  = 7;
  localparam int LINE_W = 3;
  localparam int GC_W   = $clog2(CELL_WIDTH + 1);
  localparam int TAB_W  = $clog2(TAB_CELLS + 1);
  localparam int RECIP  = (256 + CELL_WIDTH - 1) / CELL_WIDTH;

  localparam logic [1:0] ACT_FONT  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_CHAR  = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DEC, S_CLEAR, S_BS, S_GL_CHK, S_GL_RD, S_GL_WR,
    S_SC_RD, S_SC_WR, S_SC_ZERO, S_RESP
  } state_t;

  typedef struct packed {
    logic latch;
    logic font_wr;
    logic rd_item;
    logic rd_scroll;
    logic glyph_rd;
    logic wr_zero_cnt;
    logic wr_scroll;
    logic wr_glyph;
    logic wr_bs;
    logic cnt_clr;
    logic cnt_inc;
    logic gc_clr;
    logic gc_inc;
    logic home;
    logic newline_step;
    logic col_zero;
    logic advance;
    logic bs_back;
    logic tab_init;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       is_nl;
    logic       is_cr;
    logic       is_bs;
    logic       bs_ok;
    logic       cnt_last;
    logic       cnt_scroll_end;
    logic       wrap;
    logic       last_line;
    logic       gc_last;
    logic       tab_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/tcpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcpr_ctrl
// Sequencer: decodes each item and steps the datapath through font load,
// clear, read, glyph draw, backspace and scroll sequences.
// ----------------------------------------------------------------------------
module tcpr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcpr_pkg::sts_t sts,
  output tcpr_pkg::cmd_t cmd
);
  import tcpr_pkg::*;

  state_t state_r, state_nxt;
  logic   draw_pend_r, draw_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      draw_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      draw_pend_r <= draw_pend_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    draw_pend_nxt = draw_pend_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.wr_zero_cnt = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          cmd.cnt_clr = 1'b1;
          cmd.gc_clr = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.act)
          ACT_FONT: begin
            cmd.font_wr = 1'b1;
            state_nxt   = S_RESP;
          end
          ACT_CLEAR: begin
            cmd.home  = 1'b1;
            state_nxt = S_CLEAR;
          end
          ACT_CHAR: begin
            if (sts.is_nl) begin
              if (sts.last_line) begin
                cmd.col_zero  = 1'b1;
                draw_pend_nxt = 1'b0;
                state_nxt     = S_SC_RD;
              end else begin
                cmd.newline_step = 1'b1;
                state_nxt        = S_RESP;
              end
            end else if (sts.is_cr) begin
              cmd.col_zero = 1'b1;
              state_nxt    = S_RESP;
            end else if (sts.is_bs) begin
              if (sts.bs_ok) begin
                cmd.bs_back = 1'b1;
                state_nxt   = S_BS;
              end else begin
                state_nxt = S_RESP;
              end
            end else begin
              cmd.tab_init = 1'b1;
              state_nxt    = S_GL_CHK;
            end
          end
          default: begin
            cmd.rd_item = 1'b1;
            state_nxt   = S_RESP;
          end
        endcase
      end
      S_CLEAR: begin
        cmd.wr_zero_cnt = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (sts.cnt_last) state_nxt = S_RESP;
      end
      S_BS: begin
        cmd.wr_bs  = 1'b1;
        cmd.gc_inc = 1'b1;
        if (sts.gc_last) state_nxt = S_RESP;
      end
      S_GL_CHK: begin
        cmd.gc_clr  = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_GL_RD;
        if (sts.wrap) begin
          if (sts.last_line) begin
            cmd.col_zero  = 1'b1;
            draw_pend_nxt = 1'b1;
            state_nxt     = S_SC_RD;
          end else begin
            cmd.newline_step = 1'b1;
          end
        end
      end
      S_GL_RD: begin
        cmd.glyph_rd = 1'b1;
        state_nxt    = S_GL_WR;
      end
      S_GL_WR: begin
        cmd.wr_glyph = 1'b1;
        cmd.gc_inc   = 1'b1;
        if (sts.gc_last) begin
          cmd.advance = 1'b1;
          state_nxt   = sts.tab_last ? S_RESP : S_GL_CHK;
        end else begin
          state_nxt = S_GL_RD;
        end
      end
      S_SC_RD: begin
        cmd.rd_scroll = 1'b1;
        state_nxt     = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.wr_scroll = 1'b1;
        cmd.cnt_inc   = 1'b1;
        state_nxt     = sts.cnt_scroll_end ? S_SC_ZERO : S_SC_RD;
      end
      S_SC_ZERO: begin
        cmd.wr_zero_cnt = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (sts.cnt_last) state_nxt = draw_pend_r ? S_GL_RD : S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/tcpr_dp.sv =====
// ----------------------------------------------------------------------------
// tcpr_dp
// Datapath: item register, cursor, counters, framebuffer and glyph memories,
// output register.
// ----------------------------------------------------------------------------
module tcpr_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_char_code,
  input  logic [9:0]           in_address,
  input  logic [7:0]           in_font_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_read_data,
  output logic [6:0]           out_cursor_column,
  output logic [2:0]           out_cursor_line,
  input  tcpr_pkg::cmd_t       cmd,
  output tcpr_pkg::sts_t       sts
);
  import tcpr_pkg::*;

  logic [1:0]        act_r;
  logic [7:0]        code_r;
  logic [9:0]        addr_r;
  logic [7:0]        fdata_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [FB_AW-1:0]  cnt_r;
  logic [GC_W-1:0]   gc_r;
  logic [TAB_W-1:0]  tab_r;
  logic              out_valid_r;
  logic [7:0]        out_rd_r;
  logic [COL_W-1:0]  out_col_r;
  logic [LINE_W-1:0] out_line_r;

  logic [7:0] fb_mem [FRAME_SIZE];
  logic [7:0] gl_mem [GLYPH_SIZE];
  logic [7:0] fb_q;
  logic [7:0] gl_q;

  logic [FB_AW-1:0]     base;
  logic                 fb_we;
  logic [FB_AW-1:0]     fb_wa;
  logic [7:0]           fb_wd;
  logic [FB_AW-1:0]     fb_ra;
  logic [7:0]           code_eff;
  logic [GL_AW-1:0]     gl_ra;
  logic [COL_W+8:0]     cell_prod;
  logic [TAB_W-1:0]     tab_init_val;
  logic                 in_font;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r   <= in_action;
      code_r  <= in_char_code;
      addr_r  <= in_address;
      fdata_r <= in_font_data;
    end
  end

  assign base = FB_AW'(int'(line_r) * COLUMNS + int'(col_r));

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    if (cmd.home) begin
      col_nxt  = '0;
      line_nxt = '0;
    end else if (cmd.newline_step) begin
      col_nxt  = '0;
      line_nxt = line_r + LINE_W'(1);
    end else if (cmd.col_zero) begin
      col_nxt = '0;
    end else if (cmd.advance) begin
      col_nxt = col_r + COL_W'(CELL_WIDTH);
    end else if (cmd.bs_back) begin
      col_nxt = col_r - COL_W'(CELL_WIDTH);
    end
  end

  assign cell_prod    = (COL_W+9)'(col_r) * (COL_W+9)'(RECIP);
  assign tab_init_val = (code_r == CH_TAB) ?
                        TAB_W'(TAB_CELLS) - TAB_W'(cell_prod[9:8]) : TAB_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      line_r      <= '0;
      cnt_r       <= '0;
      gc_r        <= '0;
      tab_r       <= TAB_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
      if (cmd.cnt_clr)      cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + FB_AW'(1);
      if (cmd.gc_clr)       gc_r <= '0;
      else if (cmd.gc_inc)  gc_r <= gc_r + GC_W'(1);
      if (cmd.tab_init)     tab_r <= tab_init_val;
      else if (cmd.advance) tab_r <= tab_r - TAB_W'(1);
      if (cmd.load_out)     out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rd_r   <= (act_r == ACT_READ) ? fb_q : 8'd0;
      out_col_r  <= col_r;
      out_line_r <= line_r;
    end
  end

  always_comb begin
    fb_we = 1'b0;
    fb_wa = cnt_r;
    fb_wd = 8'd0;
    if (cmd.wr_zero_cnt) begin
      fb_we = 1'b1;
    end else if (cmd.wr_scroll) begin
      fb_we = 1'b1;
      fb_wd = fb_q;
    end else if (cmd.wr_glyph) begin
      fb_we = 1'b1;
      fb_wa = base + FB_AW'(gc_r);
      fb_wd = (gc_r == GC_W'(GLYPH_COLUMNS)) ? 8'd0 : gl_q;
    end else if (cmd.wr_bs) begin
      fb_we = 1'b1;
      fb_wa = base + FB_AW'(gc_r);
    end
  end

  assign fb_ra = cmd.rd_item ? FB_AW'(addr_r) : cnt_r + FB_AW'(COLUMNS);

  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_wa] <= fb_wd;
    if (cmd.rd_item || cmd.rd_scroll) fb_q <= fb_mem[fb_ra];
  end

  always_comb begin
    if (code_r == CH_TAB) begin
      code_eff = 8'(SPACE_CODE);
    end else if (code_r < 8'(FIRST_CODE) || code_r > 8'(LAST_CODE)) begin
      code_eff = 8'(FALLBACK_CODE);
    end else begin
      code_eff = code_r;
    end
  end

  assign gl_ra   = GL_AW'((int'(code_eff) - FIRST_CODE) * GLYPH_COLUMNS + int'(gc_r));
  assign in_font = (int'(addr_r) < GLYPH_SIZE);

  always_ff @(posedge clk) begin
    if (cmd.font_wr && in_font) gl_mem[GL_AW'(addr_r)] <= fdata_r;
    if (cmd.glyph_rd) gl_q <= gl_mem[gl_ra];
  end

  always_comb begin
    sts.act            = act_r;
    sts.is_nl          = (code_r == CH_NL);
    sts.is_cr          = (code_r == CH_CR);
    sts.is_bs          = (code_r == CH_BS);
    sts.bs_ok          = (col_r >= COL_W'(CELL_WIDTH));
    sts.cnt_last       = (cnt_r == FB_AW'(FRAME_SIZE - 1));
    sts.cnt_scroll_end = (cnt_r == FB_AW'(FRAME_SIZE - COLUMNS - 1));
    sts.wrap           = ((COL_W+2)'(col_r) + (COL_W+2)'(CELL_WIDTH)) >
                         (COL_W+2)'(COLUMNS);
    sts.last_line      = (line_r == LINE_W'(LINES - 1));
    sts.gc_last        = (gc_r == GC_W'(GLYPH_COLUMNS));
    sts.tab_last       = (tab_r == TAB_W'(1));
    sts.out_free       = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_line   = out_line_r;

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.wr_zero_cnt, cmd.wr_scroll, cmd.wr_glyph, cmd.wr_bs}) <= 1)
    else $error("more than one framebuffer write source");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result not presented after load");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(col_r) <= (COLUMNS / CELL_WIDTH) * CELL_WIDTH)
    else $error("cursor column past last cell");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten while held");

endmodule

// ===== rtl/text_console_page_renderer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_page_renderer_top
// Text console renderer into a 128 x 8-page framebuffer with loadable font.
//
// Input channel in_valid/in_ready carries one item: action, char_code,
// address, font_data. Output channel out_valid/out_ready returns one result
// per item: read_data, cursor_column, cursor_line.
// A scroll (newline on the last page, or a wrap there) moves each byte up
// one page with a framebuffer read then a write, then zeroes the last page.
// A new item is taken once the previous one has finished; its result waits
// in the output register while the next item is taken. A stalled receiver
// holds the controller in its response state until the register frees.
// After reset the framebuffer is cleared with in_ready low.
// ----------------------------------------------------------------------------
module text_console_page_renderer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_char_code,
  input  logic [9:0] in_address,
  input  logic [7:0] in_font_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [6:0] out_cursor_column,
  output logic [2:0] out_cursor_line
);
  import tcpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcpr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_action),
    .in_char_code      (in_char_code),
    .in_address        (in_address),
    .in_font_data      (in_font_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_cursor_column (out_cursor_column),
    .out_cursor_line   (out_cursor_line),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// ===== sim/tb_text_console_page_renderer_top.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_page_renderer_top
// Self-checking bench for the text console page renderer.
//
// Loads a font, then drives directed and random items (font loads, clears,
// characters and control codes, framebuffer reads) through the input channel
// under several idle/stall mixes. A behavioral framebuffer/cursor model
// predicts every result; results are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_text_console_page_renderer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpr_pkg::*;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [9:0] address;
    logic [7:0] font_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] cursor_column;
    logic [2:0] cursor_line;
  } result_t;

  typedef struct {
    item_t   it;
    bit      has_exp;
    result_t exp;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = ACT_FONT;
  logic [7:0] in_char_code = '0;
  logic [9:0] in_address = '0;
  logic [7:0] in_font_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic [6:0] out_cursor_column;
  logic [2:0] out_cursor_line;

  text_console_page_renderer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_char_code(in_char_code),
    .in_address(in_address), .in_font_data(in_font_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_data(out_read_data), .out_cursor_column(out_cursor_column),
    .out_cursor_line(out_cursor_line)
  );

  always #5 clk = ~clk;

  logic [7:0] fb_model [FRAME_SIZE];
  logic [7:0] font_model [GLYPH_SIZE];
  int unsigned col_m, line_m;

  result_t expected_q[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 0;

  function automatic void model_newline();
    col_m = 0;
    if (line_m + 1 < LINES) line_m++;
    else begin
      for (int i = 0; i < FRAME_SIZE - COLUMNS; i++) fb_model[i] = fb_model[i + COLUMNS];
      for (int i = FRAME_SIZE - COLUMNS; i < FRAME_SIZE; i++) fb_model[i] = 8'h00;
      line_m = LINES - 1;
    end
  endfunction

  function automatic void model_glyph(int unsigned code);
    int unsigned base, g;
    if (code < FIRST_CODE || code > LAST_CODE) code = FALLBACK_CODE;
    if (col_m + CELL_WIDTH > COLUMNS) model_newline();
    base = line_m * COLUMNS + col_m;
    g = (code - FIRST_CODE) * GLYPH_COLUMNS;
    for (int c = 0; c < GLYPH_COLUMNS; c++)
      if (base + c < FRAME_SIZE) fb_model[base + c] = font_model[g + c];
    if (base + GLYPH_COLUMNS < FRAME_SIZE) fb_model[base + GLYPH_COLUMNS] = 8'h00;
    col_m += CELL_WIDTH;
  endfunction

  function automatic result_t predict_console(item_t it);
    result_t r;
    int unsigned n, base;
    r.read_data = 8'h00;
    case (it.action)
      ACT_FONT: if (it.address < GLYPH_SIZE) begin
        font_model[it.address] = it.font_data;
      end
      ACT_CLEAR: begin
        foreach (fb_model[i]) fb_model[i] = 8'h00;
        col_m = 0;
        line_m = 0;
      end
      ACT_CHAR: begin
        case (it.char_code)
          CH_NL: model_newline();
          CH_CR: col_m = 0;
          CH_TAB: begin
            n = TAB_CELLS - ((col_m / CELL_WIDTH) % TAB_CELLS);
            repeat (n) model_glyph(SPACE_CODE);
          end
          CH_BS: if (col_m >= CELL_WIDTH) begin
            col_m -= CELL_WIDTH;
            base = line_m * COLUMNS + col_m;
            for (int c = 0; c < CELL_WIDTH; c++)
              if (base + c < FRAME_SIZE) fb_model[base + c] = 8'h00;
          end
          default: model_glyph(it.char_code);
        endcase
      end
      default: if (it.address < FRAME_SIZE) r.read_data = fb_model[it.address];
    endcase
    r.cursor_column = col_m[6:0];
    r.cursor_line = line_m[2:0];
    return r;
  endfunction

  task automatic send_item(item_t it, bit has_exp = 0, result_t fixed = '0);
    result_t r;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    {in_action, in_char_code, in_address, in_font_data} <= it;
    do @(posedge clk); while (!in_ready);
    r = predict_console(it);
    if (has_exp && r !== fixed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row disagrees: table %h model %h", fixed, r);
    end
    expected_q.push_back(has_exp ? fixed : r);
  endtask

  always @(posedge clk) begin
    if (recv_hold) out_ready <= 1'b0;
    else out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h",
          out_read_data, out_cursor_column, out_cursor_line);
      end else begin
        result_t e;
        e = expected_q.pop_front();
        if (e.read_data !== out_read_data || e.cursor_column !== out_cursor_column ||
            e.cursor_line !== out_cursor_line) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rd=%h col=%0d line=%0d got rd=%h col=%0d line=%0d",
              e.read_data, e.cursor_column, e.cursor_line,
              out_read_data, out_cursor_column, out_cursor_line);
        end
      end
    end
  end

  function automatic item_t mk(logic [1:0] a, logic [7:0] c, logic [9:0] ad,
                               logic [7:0] d);
    item_t it;
    it.action = a;
    it.char_code = c;
    it.address = ad;
    it.font_data = d;
    return it;
  endfunction

  function automatic result_t res(logic [7:0] d, logic [6:0] c, logic [2:0] l);
    result_t r;
    r.read_data = d;
    r.cursor_column = c;
    r.cursor_line = l;
    return r;
  endfunction

  // Mostly printable text and control codes; occasional out-of-font bytes.
  function automatic logic [7:0] rand_char();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 8'($urandom_range(FIRST_CODE, LAST_CODE));
    if (p < 70) return CH_NL;
    if (p < 75) return CH_CR;
    if (p < 82) return CH_TAB;
    if (p < 90) return CH_BS;
    if ($urandom_range(1)) return 8'($urandom_range(0, FIRST_CODE - 1));
    return 8'($urandom_range(LAST_CODE + 1, 255));
  endfunction

  function automatic item_t rand_item();
    int unsigned p;
    p = $urandom_range(999);
    if (p < 60) return mk(ACT_FONT, 8'($urandom), 10'($urandom_range(GLYPH_SIZE - 1)),
                          8'($urandom));
    if (p < 70) return mk(ACT_FONT, 8'($urandom), 10'($urandom_range(GLYPH_SIZE, 1023)),
                          8'($urandom));
    if (p < 75) return mk(ACT_CLEAR, 8'($urandom), 10'($urandom), 8'($urandom));
    if (p < 800) return mk(ACT_CHAR, rand_char(), 10'($urandom), 8'($urandom));
    return mk(ACT_READ, 8'($urandom), 10'($urandom), 8'($urandom));
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  row_t rows[$];

  initial begin
    col_m = 0;
    line_m = 0;
    foreach (fb_model[i]) fb_model[i] = 8'h00;
    foreach (font_model[i]) font_model[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Full font first, so every glyph is defined before it is drawn.
    for (int i = 0; i < GLYPH_SIZE; i++)
      send_item(mk(ACT_FONT, 8'h00, 10'(i), 8'($urandom)));

    rows.push_back('{mk(ACT_READ, 8'hFF, 10'd0, 8'hFF), 1, res(8'h00, 7'd0, 3'd0)});
    rows.push_back('{mk(ACT_READ, 8'h00, 10'd1023, 8'h00), 1, res(8'h00, 7'd0, 3'd0)});
    rows.push_back('{mk(ACT_FONT, 8'h00, 10'd1023, 8'hFF), 1, res(8'h00, 7'd0, 3'd0)});
    rows.push_back('{mk(ACT_FONT, 8'h00, 10'(GLYPH_SIZE), 8'hAA), 1,
                     res(8'h00, 7'd0, 3'd0)});
    rows.push_back('{mk(ACT_CHAR, CH_BS, 10'd0, 8'd0), 1, res(8'h00, 7'd0, 3'd0)});
    rows.push_back('{mk(ACT_CHAR, 8'h41, 10'd0, 8'd0), 1, res(8'h00, 7'd6, 3'd0)});
    rows.push_back('{mk(ACT_CHAR, 8'h00, 10'd0, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_CHAR, 8'hFF, 10'd0, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_CHAR, 8'h7F, 10'd0, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_CHAR, 8'h20, 10'd0, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_CHAR, 8'h7E, 10'd0, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_CHAR, CH_TAB, 10'd0, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_CHAR, CH_BS, 10'd0, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_READ, 8'h00, 10'd0, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_CHAR, CH_CR, 10'd0, 8'd0), 1, res(8'h00, 7'd0, 3'd0)});
    for (int i = 0; i < 7; i++)
      rows.push_back('{mk(ACT_CHAR, CH_NL, 10'd0, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_CHAR, CH_NL, 10'd0, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_READ, 8'h00, 10'd1023, 8'd0), 0, '0});
    rows.push_back('{mk(ACT_CLEAR, 8'hFF, 10'h3FF, 8'hFF), 1, res(8'h00, 7'd0, 3'd0)});
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_exp, rows[i].exp);

    // Fill every line to force a wrap and a scroll on the last page.
    for (int i = 0; i < 8 * 22 + 3; i++)
      send_item(mk(ACT_CHAR, 8'($urandom_range(FIRST_CODE, LAST_CODE)), 10'd0, 8'd0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 46; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 46; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int i = 0; i < 230; i++) begin
        item_t it;
        if (ph == 2 && i == 100) fork
          begin
            recv_hold = 1;
            repeat (400) @(posedge clk);
            recv_hold = 0;
          end
        join_none
        if (ph == 1 && i == 150) drain();
        it = rand_item();
        // Random items over all actions; scrolls occur naturally.
        send_item(it);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (4000) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("text_console_page_renderer_top verification clean");
    else
      $display("text_console_page_renderer_top verification failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("text_console_page_renderer_top verification failed");
    $finish;
  end
endmodule
